### rtl/prle_pkg.sv
// ----------------------------------------------------------------------------
// prle_pkg
// shared types and constants for the pcx rle decoder and word packer
// ----------------------------------------------------------------------------
package prle_pkg;

  localparam logic [7:0] MARK_MASK = 8'hc0;
  localparam logic [7:0] LEN_MASK  = 8'h3f;
  localparam int         PIX_W     = 8;
  localparam int         LEN_W     = 6;
  localparam int         NUM_W     = 24;

  // commands from controller to datapath
  typedef struct packed {
    logic take;      // an input byte is accepted this cycle
    logic emit_run;  // emit one word of the current run
  } prle_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_free;       // output register can load this cycle
    logic starts_run;     // the byte at the input would start a run of words
    logic last_run_word;  // the run word emitted now is its last
  } prle_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } prle_state_t;

endpackage

### rtl/prle_ctrl.sv
// ----------------------------------------------------------------------------
// prle_ctrl
// sequencer: accepts bytes, holds off input while run words go out
// ----------------------------------------------------------------------------
module prle_ctrl
  import prle_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  prle_stat_t stat,
  output prle_cmd_t  cmd
);

  prle_state_t state_r, state_nxt;

  always_comb begin
    in_tready    = (state_r == ST_IDLE) && stat.out_free;
    cmd.take     = in_tready && in_tvalid;
    cmd.emit_run = (state_r == ST_RUN) && stat.out_free;
    state_nxt    = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.take && stat.starts_run) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (cmd.emit_run && stat.last_run_word) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/prle_dpath.sv
// ----------------------------------------------------------------------------
// prle_dpath
// decoder state, word packing, word counter and output register
// ----------------------------------------------------------------------------
module prle_dpath
  import prle_pkg::*;
#(
  parameter int COUNT_BITS = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  input  prle_cmd_t        cmd,
  output prle_stat_t       stat,
  input  logic [PIX_W-1:0] data_byte,
  input  logic             final_byte,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [15:0]      pixel_word,
  output logic [NUM_W-1:0] word_number,
  output logic             last_of_item
);

  logic                  await_r, await_nxt;
  logic [LEN_W-1:0]      plen_r, plen_nxt;
  logic                  hold_r, hold_nxt;
  logic [PIX_W-1:0]      held_r, held_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [PIX_W-1:0]      run_px_r, run_px_nxt;
  logic [LEN_W-1:0]      rem_r, rem_nxt;
  logic                  nhold_r, nhold_nxt;
  logic                  fin_r, fin_nxt;
  logic                  ov_r, ov_nxt;
  logic [15:0]           word_r, word_nxt;
  logic [NUM_W-1:0]      num_r, num_nxt;
  logic                  last_r, last_nxt;

  logic [LEN_W:0]             pix_sum;
  logic [LEN_W-1:0]           run_words;
  logic [COUNT_BITS-1:0]      count_inc;
  logic [COUNT_BITS+NUM_W-1:0] count_ext;
  logic                       is_mark;

  always_comb begin
    pix_sum   = {1'b0, plen_r} + {{LEN_W{1'b0}}, hold_r};
    run_words = pix_sum[LEN_W:1];
    count_inc = count_r + {{(COUNT_BITS-1){1'b0}}, 1'b1};
    count_ext = {{NUM_W{1'b0}}, count_inc};
    is_mark   = (data_byte & MARK_MASK) == MARK_MASK;

    stat.out_free      = !ov_r || out_ready;
    stat.starts_run    = await_r && (run_words != '0);
    stat.last_run_word = rem_r == {{(LEN_W-1){1'b0}}, 1'b1};

    await_nxt  = await_r;
    plen_nxt   = plen_r;
    hold_nxt   = hold_r;
    held_nxt   = held_r;
    count_nxt  = count_r;
    run_px_nxt = run_px_r;
    rem_nxt    = rem_r;
    nhold_nxt  = nhold_r;
    fin_nxt    = fin_r;
    ov_nxt     = ov_r && !out_ready;
    word_nxt   = word_r;
    num_nxt    = num_r;
    last_nxt   = last_r;

    if (cmd.take) begin
      if (await_r) begin
        await_nxt = 1'b0;
        plen_nxt  = '0;
        if (run_words != '0) begin
          run_px_nxt = data_byte;
          rem_nxt    = run_words;
          nhold_nxt  = pix_sum[0];
          fin_nxt    = final_byte;
        end else if (plen_r != '0) begin
          // single pixel run becomes the held high pixel
          hold_nxt = 1'b1;
          held_nxt = data_byte;
        end
      end else if (is_mark) begin
        await_nxt = 1'b1;
        plen_nxt  = data_byte[LEN_W-1:0];
      end else if (hold_r) begin
        ov_nxt    = 1'b1;
        word_nxt  = {held_r, data_byte};
        num_nxt   = count_ext[NUM_W-1:0];
        last_nxt  = 1'b1;
        count_nxt = count_inc;
        hold_nxt  = 1'b0;
      end else begin
        hold_nxt = 1'b1;
        held_nxt = data_byte;
      end
      // a run that emits words clears at its last word instead
      if (final_byte && !stat.starts_run) begin
        await_nxt = 1'b0;
        plen_nxt  = '0;
        hold_nxt  = 1'b0;
        held_nxt  = '0;
        count_nxt = '0;
      end
    end

    if (cmd.emit_run) begin
      ov_nxt    = 1'b1;
      word_nxt  = {(hold_r ? held_r : run_px_r), run_px_r};
      num_nxt   = count_ext[NUM_W-1:0];
      last_nxt  = stat.last_run_word;
      count_nxt = count_inc;
      hold_nxt  = 1'b0;
      rem_nxt   = rem_r - {{(LEN_W-1){1'b0}}, 1'b1};
      if (stat.last_run_word) begin
        hold_nxt = nhold_r;
        held_nxt = run_px_r;
        if (fin_r) begin
          await_nxt = 1'b0;
          plen_nxt  = '0;
          hold_nxt  = 1'b0;
          held_nxt  = '0;
          count_nxt = '0;
          fin_nxt   = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      await_r <= 1'b0;
      plen_r  <= '0;
      hold_r  <= 1'b0;
      held_r  <= '0;
      count_r <= '0;
      rem_r   <= '0;
      nhold_r <= 1'b0;
      fin_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      await_r <= await_nxt;
      plen_r  <= plen_nxt;
      hold_r  <= hold_nxt;
      held_r  <= held_nxt;
      count_r <= count_nxt;
      rem_r   <= rem_nxt;
      nhold_r <= nhold_nxt;
      fin_r   <= fin_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_px_r <= run_px_nxt;
    word_r   <= word_nxt;
    num_r    <= num_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid    = ov_r;
  assign pixel_word   = word_r;
  assign word_number  = num_r;
  assign last_of_item = last_r;

endmodule

### rtl/pcx_rle_decode_pack16.sv
// ----------------------------------------------------------------------------
// pcx_rle_decode_pack16
// 8-bit pcx image rle decoder that packs pixel pairs into 16-bit words
// ----------------------------------------------------------------------------
// takes encoded image bytes one byte per handshake. a byte with both top bits
// set is a run marker whose low six bits give a repeat count (0 to 63); the
// next byte is the run pixel, whatever its value. any other byte is a literal
// pixel. pixels pair into 16-bit words, earlier pixel in the high byte, each
// with a wrapping word count. tlast on an input byte clears all decoder
// state (held odd pixel, pending marker, word count) once that byte is done.
// timing: marker and literal bytes are taken at one per cycle while the output
// register can load; each literal pair goes out through it. a run value byte
// that yields n words (n = (held + count) / 2, up to 32) holds off the input
// while the sequencer sends one run word per cycle through the same output
// register; a run yielding no word does not hold off the input. out_tready low
// stalls both sides.
// ----------------------------------------------------------------------------
module pcx_rle_decode_pack16
  import prle_pkg::*;
#(
  parameter int COUNT_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // final_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [15:0] pixel_word, [39:16] word_number
  output logic        out_tlast   // last_of_item
);

  prle_cmd_t  cmd;
  prle_stat_t stat;

  logic [15:0]      pixel_word;
  logic [NUM_W-1:0] word_number;

  // sequencer
  prle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // decoder state, packing and output register
  prle_dpath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .data_byte    (in_tdata),
    .final_byte   (in_tlast),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .pixel_word   (pixel_word),
    .word_number  (word_number),
    .last_of_item (out_tlast)
  );

  assign out_tdata = {word_number, pixel_word};

endmodule
